// File: src/cscoll_pkg.sv
// Shared types, codes and constants of the circle collision test block.
package cscoll_pkg;

  localparam int unsigned MUL_W = 70;
  localparam int unsigned PROD_W = 2 * MUL_W;

  localparam logic [2:0] KIND_GENERAL = 3'd0;
  localparam logic [2:0] KIND_RECT    = 3'd1;
  localparam logic [2:0] KIND_CIRCLE  = 3'd2;
  localparam logic [2:0] KIND_DISC    = 3'd3;
  localparam logic [2:0] KIND_SEGMENT = 3'd4;

  localparam logic [1:0] REG_CENTER_X = 2'd0;
  localparam logic [1:0] REG_CENTER_Y = 2'd1;
  localparam logic [1:0] REG_RADIUS   = 2'd2;

  localparam logic [27:0] CORDIC_K_Q28 = 28'd163008219;
  localparam logic [3:0]  CORDIC_LAST  = 4'd15;

  // Multiply operations, in issue order
  typedef enum logic [4:0] {
    OP_FX2, OP_FY2, OP_S2, OP_GX2, OP_GY2, OP_RR, OP_DX2, OP_DY2,
    OP_DXFY, OP_DYFX, OP_CR2, OP_RA, OP_DXFX, OP_DYFY, OP_DXGX, OP_DYGY,
    OP_XK, OP_YK, OP_UX2, OP_UY2, OP_R2X
  } op_e;

  localparam int unsigned OP_COUNT = 21;

  typedef enum logic [2:0] {
    RES_ZERO, RES_ONE, RES_CIRCLE, RES_RECT, RES_SEG
  } res_e;

  typedef struct packed {
    logic       load;
    logic       cordic_step;
    logic [3:0] cordic_idx;
    logic       mul_start;
    op_e        op;
    logic       finish;
    res_e       res;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       shape_ok;
    logic       mul_done;
    logic       out_free;
    logic       seg_inside;
    logic       seg_zero;
    logic       seg_far;
    logic       seg_touch;
  } sts_t;

  function automatic logic [13:0] atan_lut(input logic [3:0] idx);
    logic [13:0] v;
    case (idx)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

// File: src/cscoll_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
module cscoll_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cscoll_pkg::MUL_W-1:0] op_a_i,
  input  logic [cscoll_pkg::MUL_W-1:0] op_b_i,
  output logic [cscoll_pkg::PROD_W-1:0] prod_o,
  output logic                         done_o
);
  import cscoll_pkg::*;

  logic              busy_q;
  logic [PROD_W-1:0] acc_q, ma_q;
  logic [MUL_W-1:0]  mb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && mb_q == '0) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      ma_q  <= PROD_W'(op_a_i);
      mb_q  <= op_b_i;
    end else if (busy_q && mb_q != '0) begin
      acc_q <= acc_q + (mb_q[0] ? ma_q : '0);
      ma_q  <= ma_q << 1;
      mb_q  <= mb_q >> 1;
    end
  end

  assign prod_o = acc_q;
  assign done_o = busy_q && (mb_q == '0);
endmodule

// File: src/cscoll_ctrl.sv
// Controller: sequences CORDIC steps, multiplies and result decisions.
module cscoll_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cscoll_pkg::sts_t   sts_i,
  output cscoll_pkg::cmd_t   cmd_o
);
  import cscoll_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_CORDIC, S_MUL, S_MWAIT, S_NEXT, S_FINISH
  } state_e;

  state_e     state_q;
  op_e        op_q;
  res_e       res_q;
  logic [3:0] cnt_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = in_valid_i && (state_q == S_IDLE);
    cmd_o.cordic_step = (state_q == S_CORDIC);
    cmd_o.cordic_idx  = cnt_q;
    cmd_o.mul_start   = (state_q == S_MUL);
    cmd_o.op          = op_q;
    cmd_o.finish      = (state_q == S_FINISH) && sts_i.out_free;
    cmd_o.res         = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      op_q    <= OP_FX2;
      res_q   <= RES_ZERO;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) state_q <= S_DISPATCH;
        end
        S_DISPATCH: begin
          op_q  <= OP_FX2;
          cnt_q <= '0;
          if (!sts_i.shape_ok) begin
            res_q   <= RES_ZERO;
            state_q <= S_FINISH;
          end else begin
            case (sts_i.kind)
              KIND_RECT:                          state_q <= S_CORDIC;
              KIND_CIRCLE, KIND_DISC, KIND_SEGMENT: state_q <= S_MUL;
              default: begin
                res_q   <= RES_ZERO;
                state_q <= S_FINISH;
              end
            endcase
          end
        end
        S_CORDIC: begin
          cnt_q <= cnt_q + 4'd1;
          if (cnt_q == CORDIC_LAST) begin
            op_q    <= OP_XK;
            state_q <= S_MUL;
          end
        end
        S_MUL: state_q <= S_MWAIT;
        S_MWAIT: begin
          if (sts_i.mul_done) state_q <= S_NEXT;
        end
        S_NEXT: begin
          // Products are in place now; pick the next multiply or the result
          state_q <= S_MUL;
          case (op_q)
            OP_FY2: op_q <= (sts_i.kind == KIND_SEGMENT) ? OP_GX2 : OP_S2;
            OP_S2: begin
              res_q   <= RES_CIRCLE;
              state_q <= S_FINISH;
            end
            OP_RR: begin
              if (sts_i.seg_inside) begin
                res_q   <= RES_ONE;
                state_q <= S_FINISH;
              end else begin
                op_q <= OP_DX2;
              end
            end
            OP_DY2: begin
              if (sts_i.seg_zero) begin
                res_q   <= RES_ZERO;
                state_q <= S_FINISH;
              end else begin
                op_q <= OP_DXFY;
              end
            end
            OP_RA: begin
              if (sts_i.seg_far) begin
                res_q   <= RES_ZERO;
                state_q <= S_FINISH;
              end else if (sts_i.seg_touch) begin
                res_q   <= RES_ONE;
                state_q <= S_FINISH;
              end else begin
                op_q <= OP_DXFX;
              end
            end
            OP_DYGY: begin
              res_q   <= RES_SEG;
              state_q <= S_FINISH;
            end
            OP_R2X: begin
              res_q   <= RES_RECT;
              state_q <= S_FINISH;
            end
            default: op_q <= op_e'(op_q + 5'd1);
          endcase
        end
        S_FINISH: begin
          if (sts_i.out_free) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// File: src/cscoll_dp.sv
// Datapath: registers, CORDIC rotator, product store, compares and output register.
module cscoll_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i,
  input  logic [2:0]          kind_i,
  input  logic                shape_valid_i,
  input  logic signed [31:0]  point_ax_i,
  input  logic signed [31:0]  point_ay_i,
  input  logic signed [31:0]  point_bx_i,
  input  logic signed [31:0]  point_by_i,
  input  logic signed [31:0]  extent_a_i,
  input  logic signed [31:0]  extent_b_i,
  input  logic [15:0]         rect_angle_i,
  input  logic                last_disc_i,
  input  cscoll_pkg::cmd_t    cmd_i,
  output cscoll_pkg::sts_t    sts_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                hit_o
);
  import cscoll_pkg::*;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0]        r_q;
  logic [2:0]         kind_q;
  logic               ok_q, last_q;
  logic signed [31:0] ax_q, ay_q, bx_q, by_q, ea_q;
  logic signed [31:0] eb_q;
  logic signed [35:0] x_q, y_q;
  logic signed [15:0] z_q;
  logic               acc_q, out_valid_q, hit_q;
  logic               acc_d, out_valid_d;
  logic [PROD_W-1:0]  prod_q [OP_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      r_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CENTER_X: cx_q <= cfg_data_i;
        REG_CENTER_Y: cy_q <= cfg_data_i;
        REG_RADIUS:   r_q  <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // CORDIC: rotate center minus other center by minus the angle
  logic [14:0]        zr;
  logic signed [35:0] sx, sy;
  logic signed [15:0] at;
  assign zr = 15'(16'd0 - rect_angle_i);
  assign sx = x_q >>> cmd_i.cordic_idx;
  assign sy = y_q >>> cmd_i.cordic_idx;
  assign at = $signed({2'b00, atan_lut(cmd_i.cordic_idx)});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      ok_q   <= shape_valid_i;
      last_q <= last_disc_i;
      ax_q   <= point_ax_i;
      ay_q   <= point_ay_i;
      bx_q   <= point_bx_i;
      by_q   <= point_by_i;
      ea_q   <= extent_a_i;
      eb_q   <= extent_b_i;
      x_q    <= 36'(cx_q) - 36'(point_ax_i);
      y_q    <= 36'(cy_q) - 36'(point_ay_i);
      z_q    <= $signed({zr[14], zr});
    end else if (cmd_i.cordic_step) begin
      if (!z_q[15]) begin
        x_q <= x_q - sy;
        y_q <= y_q + sx;
        z_q <= z_q - at;
      end else begin
        x_q <= x_q + sy;
        y_q <= y_q - sx;
        z_q <= z_q + at;
      end
    end
  end

  // Differences and magnitudes
  logic signed [32:0] fx, fy, gx, gy, s, ea33, eb33;
  logic signed [33:0] dx, dy;
  logic [32:0]        fxm, fym, gxm, gym, sm, eam, ebm;
  logic [33:0]        dxm, dym;
  logic [35:0]        xm, ym;

  assign fx   = 33'(ax_q) - 33'(cx_q);
  assign fy   = 33'(ay_q) - 33'(cy_q);
  assign gx   = 33'(bx_q) - 33'(cx_q);
  assign gy   = 33'(by_q) - 33'(cy_q);
  assign dx   = 34'(bx_q) - 34'(ax_q);
  assign dy   = 34'(by_q) - 34'(ay_q);
  assign s    = $signed({2'b00, r_q}) + 33'(ea_q);
  assign ea33 = 33'(ea_q);
  assign eb33 = 33'(eb_q);
  assign fxm  = fx[32] ? -fx : fx;
  assign fym  = fy[32] ? -fy : fy;
  assign gxm  = gx[32] ? -gx : gx;
  assign gym  = gy[32] ? -gy : gy;
  assign sm   = s[32] ? -s : s;
  assign eam  = ea33[32] ? -ea33 : ea33;
  assign ebm  = eb33[32] ? -eb33 : eb33;
  assign dxm  = dx[33] ? -dx : dx;
  assign dym  = dy[33] ? -dy : dy;
  assign xm   = x_q[35] ? -x_q : x_q;
  assign ym   = y_q[35] ? -y_q : y_q;

  // Rectangle: undo gain with floor semantics, then distance outside the box
  logic [35:0]        rx, ry;
  logic signed [37:0] uxs, uys;
  logic [36:0]        ux, uy;
  assign rx  = prod_q[OP_XK][63:28] + 36'(x_q[35] && prod_q[OP_XK][27:0] != '0);
  assign ry  = prod_q[OP_YK][63:28] + 36'(y_q[35] && prod_q[OP_YK][27:0] != '0);
  assign uxs = $signed({1'b0, rx, 1'b0}) - $signed({5'b0, eam});
  assign uys = $signed({1'b0, ry, 1'b0}) - $signed({5'b0, ebm});
  assign ux  = uxs[37] ? '0 : uxs[36:0];
  assign uy  = uys[37] ? '0 : uys[36:0];

  // Segment terms
  function automatic logic signed [70:0] sgn_prod(input logic [PROD_W-1:0] p,
                                                  input logic neg);
    logic signed [70:0] v;
    v = $signed({1'b0, p[69:0]});
    return neg ? -v : v;
  endfunction

  logic [66:0]        f2, g2, r2;
  logic [67:0]        a2;
  logic signed [71:0] cr, df, dg;
  logic [71:0]        crm;
  assign f2  = 67'(prod_q[OP_FX2][65:0]) + 67'(prod_q[OP_FY2][65:0]);
  assign g2  = 67'(prod_q[OP_GX2][65:0]) + 67'(prod_q[OP_GY2][65:0]);
  assign r2  = 67'(prod_q[OP_RR][61:0]);
  assign a2  = 68'(prod_q[OP_DX2][66:0]) + 68'(prod_q[OP_DY2][66:0]);
  assign cr  = 72'(sgn_prod(prod_q[OP_DXFY], dx[33] ^ fy[32]))
             - 72'(sgn_prod(prod_q[OP_DYFX], dy[33] ^ fx[32]));
  assign df  = 72'(sgn_prod(prod_q[OP_DXFX], dx[33] ^ fx[32]))
             + 72'(sgn_prod(prod_q[OP_DYFY], dy[33] ^ fy[32]));
  assign dg  = 72'(sgn_prod(prod_q[OP_DXGX], dx[33] ^ gx[32]))
             + 72'(sgn_prod(prod_q[OP_DYGY], dy[33] ^ gy[32]));
  assign crm = cr[71] ? -cr : cr;

  // Multiplier operand select
  logic [MUL_W-1:0]  opa, opb;
  logic [PROD_W-1:0] prod;
  logic              mul_done;

  always_comb begin
    case (cmd_i.op)
      OP_FX2:  begin opa = MUL_W'(fxm);  opb = MUL_W'(fxm); end
      OP_FY2:  begin opa = MUL_W'(fym);  opb = MUL_W'(fym); end
      OP_S2:   begin opa = MUL_W'(sm);   opb = MUL_W'(sm);  end
      OP_GX2:  begin opa = MUL_W'(gxm);  opb = MUL_W'(gxm); end
      OP_GY2:  begin opa = MUL_W'(gym);  opb = MUL_W'(gym); end
      OP_RR:   begin opa = MUL_W'(r_q);  opb = MUL_W'(r_q); end
      OP_DX2:  begin opa = MUL_W'(dxm);  opb = MUL_W'(dxm); end
      OP_DY2:  begin opa = MUL_W'(dym);  opb = MUL_W'(dym); end
      OP_DXFY: begin opa = MUL_W'(dxm);  opb = MUL_W'(fym); end
      OP_DYFX: begin opa = MUL_W'(dym);  opb = MUL_W'(fxm); end
      OP_CR2:  begin opa = crm[69:0];    opb = crm[69:0];   end
      OP_RA:   begin opa = MUL_W'(a2);   opb = MUL_W'(r2);  end
      OP_DXFX: begin opa = MUL_W'(dxm);  opb = MUL_W'(fxm); end
      OP_DYFY: begin opa = MUL_W'(dym);  opb = MUL_W'(fym); end
      OP_DXGX: begin opa = MUL_W'(dxm);  opb = MUL_W'(gxm); end
      OP_DYGY: begin opa = MUL_W'(dym);  opb = MUL_W'(gym); end
      OP_XK:   begin opa = MUL_W'(xm);   opb = MUL_W'(CORDIC_K_Q28); end
      OP_YK:   begin opa = MUL_W'(ym);   opb = MUL_W'(CORDIC_K_Q28); end
      OP_UX2:  begin opa = MUL_W'(ux);   opb = MUL_W'(ux);  end
      OP_UY2:  begin opa = MUL_W'(uy);   opb = MUL_W'(uy);  end
      OP_R2X:  begin opa = MUL_W'({r_q, 1'b0}); opb = MUL_W'({r_q, 1'b0}); end
      default: begin opa = '0;           opb = '0;          end
    endcase
  end

  cscoll_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .op_a_i  (opa),
    .op_b_i  (opb),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  always_ff @(posedge clk_i) begin
    if (mul_done) prod_q[cmd_i.op] <= prod;
  end

  // Result select
  logic res_hit;
  always_comb begin
    case (cmd_i.res)
      RES_ONE:    res_hit = 1'b1;
      RES_CIRCLE: res_hit = !s[32] && (f2 <= 67'(prod_q[OP_S2][65:0]));
      RES_RECT:   res_hit = (75'(prod_q[OP_UX2][73:0]) + 75'(prod_q[OP_UY2][73:0]))
                            < 75'(prod_q[OP_R2X][63:0]);
      RES_SEG:    res_hit = (df[71] || df == '0) && !dg[71];
      default:    res_hit = 1'b0;
    endcase
  end

  // Drop the result on transfer; a disc not marked last only folds into the run
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    acc_d       = acc_q;
    if (cmd_i.finish) begin
      if (kind_q == KIND_DISC && !last_q) begin
        acc_d = acc_q | res_hit;
      end else begin
        out_valid_d = 1'b1;
        if (kind_q == KIND_DISC) acc_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) hit_q <= (kind_q == KIND_DISC) ? (acc_q | res_hit) : res_hit;
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  always_comb begin
    sts_o            = '0;
    sts_o.kind       = kind_q;
    sts_o.shape_ok   = ok_q;
    sts_o.mul_done   = mul_done;
    sts_o.out_free   = !out_valid_q || out_ready_i;
    sts_o.seg_inside = (f2 < r2) || (g2 < r2);
    sts_o.seg_zero   = (a2 == '0);
    sts_o.seg_far    = prod_q[OP_CR2] >= prod_q[OP_RA];
    sts_o.seg_touch  = (f2 == r2) || (g2 == r2);
  end
endmodule

// File: src/circle_shape_collision_test_core.sv
// Top level of the circle collision test: stream ports, controller and datapath.
//
//  channel   direction  fields
//  s_axis    in         tdata: shape geometry, tuser: kind/valid, tlast: last disc
//  m_axis    out        tdata: hit
//  cfg       in         center_x, center_y, radius writes
//
// One item is in work at a time. Each multiply runs in the shift-add multiplier
// until its second operand is shifted out: a rectangle takes the CORDIC steps plus
// five multiplies, a segment up to 15 multiplies. Invalid and general shapes take
// no multiply. Reset clears control, the configuration registers and the disc run
// flag. A stalled result holds in the output register; the next item is taken
// while it waits.
module circle_shape_collision_test_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_ax, point_ay, point_bx, point_by, extent_a, extent_b, rect_angle
  input  logic [207:0] s_axis_tdata,
  // kind, shape_valid
  input  logic [3:0]   s_axis_tuser,
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit
  output logic [7:0]   m_axis_tdata
);
  import cscoll_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic hit;

  cscoll_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cscoll_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (s_axis_tuser[2:0]),
    .shape_valid_i (s_axis_tuser[3]),
    .point_ax_i    ($signed(s_axis_tdata[31:0])),
    .point_ay_i    ($signed(s_axis_tdata[63:32])),
    .point_bx_i    ($signed(s_axis_tdata[95:64])),
    .point_by_i    ($signed(s_axis_tdata[127:96])),
    .extent_a_i    ($signed(s_axis_tdata[159:128])),
    .extent_b_i    ($signed(s_axis_tdata[191:160])),
    .rect_angle_i  (s_axis_tdata[207:192]),
    .last_disc_i   (s_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .hit_o         (hit)
  );

  assign m_axis_tdata = {7'd0, hit};
endmodule

// File: src/cscoll_checker.sv
// Port-level checks of the collision test core and their bind.
module cscoll_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [7:0]   m_axis_tdata
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second item taken while one is in work");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("result padding not zero");
endmodule

bind circle_shape_collision_test_core cscoll_checker u_cscoll_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
